@@ design/dcrr_pkg.sv @@
// Shared types, constants and the CRC-32 byte update for the dual-copy record resolver.
package dcrr_pkg;

  localparam int unsigned DEF_HDR_BYTES    = 32;
  localparam int unsigned DEF_BODY_BYTES   = 96;
  localparam int unsigned DEF_SEQ_OFFSET   = 8;
  localparam int unsigned DEF_CRC_OFFSET   = 12;
  localparam int unsigned DEF_FLAGS_OFFSET = 16;

  localparam int unsigned MAGIC_OFFSET  = 0;
  localparam int unsigned SCHEMA_OFFSET = 4;
  localparam int unsigned LENGTH_OFFSET = 6;

  localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [31:0] MAX_SCHEMA_RESET = 32'd1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_EXPECTED_MAGIC = 1'b0,
    REG_MAX_SCHEMA     = 1'b1
  } cfg_reg_t;

  // Verdict of the copy in flight, including the byte being processed
  typedef struct packed {
    logic        ok;
    logic [31:0] seq;
    logic [31:0] flags;
  } copy_verdict_t;

  typedef struct packed {
    logic        config_found;
    logic        chosen_copy;
    logic [31:0] chosen_seq;
    logic [31:0] chosen_flags;
    logic        first_valid;
    logic        second_valid;
    logic [31:0] next_seq;
    logic        write_target;
  } result_t;

  // Reflected CRC-32, one byte, bit at a time (eight narrow steps)
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ design/dual_copy_record_resolver.sv @@
// Top level of the dual-copy record resolver: input register, copy tracking, result register.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    data_byte, copy_index, read_fault, last_byte
//   out      source     out_valid / out_ready  config_found ... write_target
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte per cycle sustained. A byte sits in the input register, where the
// header capture, the unrolled CRC-32 byte update and the verdict run; the result of the
// last byte of copy 1 is written to the output register when that byte steps out of it.
// A stalled result blocks only the closing byte of the next copy 1 and the input behind it;
// all other bytes flow.
// rst is synchronous; it clears all copy state and sets the registers to their reset values.
module dual_copy_record_resolver #(
  parameter int unsigned HDR_BYTES    = dcrr_pkg::DEF_HDR_BYTES,
  parameter int unsigned BODY_BYTES   = dcrr_pkg::DEF_BODY_BYTES,
  parameter int unsigned SEQ_OFFSET   = dcrr_pkg::DEF_SEQ_OFFSET,
  parameter int unsigned CRC_OFFSET   = dcrr_pkg::DEF_CRC_OFFSET,
  parameter int unsigned FLAGS_OFFSET = dcrr_pkg::DEF_FLAGS_OFFSET
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        copy_index,
  input  logic        read_fault,
  input  logic        last_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        config_found,
  output logic        chosen_copy,
  output logic [31:0] chosen_seq,
  output logic [31:0] chosen_flags,
  output logic        first_valid,
  output logic        second_valid,
  output logic [31:0] next_seq,
  output logic        write_target,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import dcrr_pkg::*;

  logic [31:0]   expected_magic;
  logic [15:0]   max_schema;

  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          s1_copy;
  logic          s1_fault;
  logic          s1_last;

  logic          out_free;
  logic          step;
  logic          report;
  copy_verdict_t verdict;
  result_t       result;
  result_t       out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic <= '0;
      max_schema     <= MAX_SCHEMA_RESET[15:0];
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_EXPECTED_MAGIC: expected_magic <= cfg_data;
        REG_MAX_SCHEMA:     max_schema     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // only the closing byte of copy 1 needs room in the output register
  assign out_free = !out_valid || out_ready;
  assign step     = s1_valid && (!(s1_last && s1_copy) || out_free);
  assign in_ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte  <= data_byte;
      s1_copy  <= copy_index;
      s1_fault <= read_fault;
      s1_last  <= last_byte;
    end
  end

  dcrr_copy_track #(
    .HDR_BYTES   (HDR_BYTES),
    .BODY_BYTES  (BODY_BYTES),
    .SEQ_OFFSET  (SEQ_OFFSET),
    .CRC_OFFSET  (CRC_OFFSET),
    .FLAGS_OFFSET(FLAGS_OFFSET)
  ) u_track (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data_byte     (s1_byte),
    .read_fault    (s1_fault),
    .last_byte     (s1_last),
    .expected_magic(expected_magic),
    .max_schema    (max_schema),
    .verdict       (verdict)
  );

  dcrr_select u_select (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .copy_index(s1_copy),
    .last_byte (s1_last),
    .verdict   (verdict),
    .report    (report),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report) begin
      out_res <= result;
    end
  end

  assign config_found = out_res.config_found;
  assign chosen_copy  = out_res.chosen_copy;
  assign chosen_seq   = out_res.chosen_seq;
  assign chosen_flags = out_res.chosen_flags;
  assign first_valid  = out_res.first_valid;
  assign second_valid = out_res.second_valid;
  assign next_seq     = out_res.next_seq;
  assign write_target = out_res.write_target;

endmodule

@@ design/dcrr_copy_track.sv @@
// Per-copy header capture, body CRC-32 and integrity verdict.
module dcrr_copy_track #(
  parameter int unsigned HDR_BYTES    = dcrr_pkg::DEF_HDR_BYTES,
  parameter int unsigned BODY_BYTES   = dcrr_pkg::DEF_BODY_BYTES,
  parameter int unsigned SEQ_OFFSET   = dcrr_pkg::DEF_SEQ_OFFSET,
  parameter int unsigned CRC_OFFSET   = dcrr_pkg::DEF_CRC_OFFSET,
  parameter int unsigned FLAGS_OFFSET = dcrr_pkg::DEF_FLAGS_OFFSET
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              data_byte,
  input  logic                    read_fault,
  input  logic                    last_byte,
  input  logic [31:0]             expected_magic,
  input  logic [15:0]             max_schema,
  output dcrr_pkg::copy_verdict_t verdict
);
  import dcrr_pkg::*;

  localparam int unsigned REC_LEN = HDR_BYTES + BODY_BYTES;
  localparam int unsigned CNT_W   = $clog2(REC_LEN + 1);

  logic [31:0]      crc_reg;
  logic [CNT_W-1:0] byte_count;
  logic [31:0]      magic_word;
  logic [15:0]      schema_word;
  logic [15:0]      length_word;
  logic [31:0]      seq_word;
  logic [31:0]      stored_crc;
  logic [31:0]      flags_word;
  logic             fault_seen;

  logic [31:0]      crc_next;
  logic [CNT_W-1:0] byte_count_next;
  logic [31:0]      magic_word_next;
  logic [15:0]      schema_word_next;
  logic [15:0]      length_word_next;
  logic [31:0]      seq_word_next;
  logic [31:0]      stored_crc_next;
  logic [31:0]      flags_word_next;
  logic             fault_seen_next;
  logic [31:0]      pos;

  assign pos = {{(32 - CNT_W){1'b0}}, byte_count};

  always_comb begin
    crc_next         = crc_reg;
    byte_count_next  = byte_count;
    magic_word_next  = magic_word;
    schema_word_next = schema_word;
    length_word_next = length_word;
    seq_word_next    = seq_word;
    stored_crc_next  = stored_crc;
    flags_word_next  = flags_word;
    fault_seen_next  = fault_seen | read_fault;
    // data of bytes past the record is ignored (their read faults still count), count saturates
    if (byte_count < CNT_W'(REC_LEN)) begin
      for (int k = 0; k < 4; k++) begin
        if (pos == 32'(MAGIC_OFFSET + k)) magic_word_next[8*k +: 8] = data_byte;
        if (pos == 32'(SEQ_OFFSET + k))   seq_word_next[8*k +: 8]   = data_byte;
        if (pos == 32'(CRC_OFFSET + k))   stored_crc_next[8*k +: 8] = data_byte;
        if (pos == 32'(FLAGS_OFFSET + k)) flags_word_next[8*k +: 8] = data_byte;
      end
      for (int k = 0; k < 2; k++) begin
        if (pos == 32'(SCHEMA_OFFSET + k)) schema_word_next[8*k +: 8] = data_byte;
        if (pos == 32'(LENGTH_OFFSET + k)) length_word_next[8*k +: 8] = data_byte;
      end
      if (byte_count >= CNT_W'(HDR_BYTES)) crc_next = crc_byte(crc_reg, data_byte);
      byte_count_next = byte_count + CNT_W'(1);
    end
  end

  always_comb begin
    verdict.ok = !fault_seen_next
              && (byte_count_next == CNT_W'(REC_LEN))
              && (magic_word_next == expected_magic)
              && (schema_word_next <= max_schema)
              && (length_word_next == 16'(REC_LEN))
              && (stored_crc_next == (crc_next ^ CRC_SEED));
    verdict.seq   = seq_word_next;
    verdict.flags = flags_word_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      crc_reg     <= CRC_SEED;
      byte_count  <= '0;
      magic_word  <= '0;
      schema_word <= '0;
      length_word <= '0;
      seq_word    <= '0;
      stored_crc  <= '0;
      flags_word  <= '0;
      fault_seen  <= 1'b0;
    end else if (step) begin
      crc_reg     <= crc_next;
      byte_count  <= byte_count_next;
      magic_word  <= magic_word_next;
      schema_word <= schema_word_next;
      length_word <= length_word_next;
      seq_word    <= seq_word_next;
      stored_crc  <= stored_crc_next;
      flags_word  <= flags_word_next;
      fault_seen  <= fault_seen_next;
    end
  end

endmodule

@@ design/dcrr_select.sv @@
// Copy 0 verdict hold and the copy selection / commit plan.
module dcrr_select (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    copy_index,
  input  logic                    last_byte,
  input  dcrr_pkg::copy_verdict_t verdict,
  output logic                    report,
  output dcrr_pkg::result_t       result
);
  import dcrr_pkg::*;

  logic        slot0_valid;
  logic [31:0] slot0_seq;
  logic [31:0] slot0_flags;

  logic        v0;
  logic        v1;
  logic [31:0] s0;
  logic [31:0] s1;
  logic        s0_ge;

  assign report = step && last_byte && copy_index;

  always_comb begin
    v0    = slot0_valid;
    v1    = verdict.ok;
    s0    = v0 ? slot0_seq : 32'd0;
    s1    = v1 ? verdict.seq : 32'd0;
    s0_ge = (s0 >= s1);

    result.config_found = v0 | v1;
    result.first_valid  = v0;
    result.second_valid = v1;
    result.next_seq     = (s0_ge ? s0 : s1) + 32'd1;

    if (v0 && (!v1 || s0_ge)) begin
      result.chosen_copy  = 1'b0;
      result.chosen_seq   = s0;
      result.chosen_flags = slot0_flags;
    end else if (v1) begin
      result.chosen_copy  = 1'b1;
      result.chosen_seq   = s1;
      result.chosen_flags = verdict.flags;
    end else begin
      result.chosen_copy  = 1'b0;
      result.chosen_seq   = 32'd0;
      result.chosen_flags = 32'd0;
    end

    // tie on sequence overwrites copy 0
    if (!v0)      result.write_target = 1'b0;
    else if (!v1) result.write_target = 1'b1;
    else          result.write_target = (s0 <= s1) ? 1'b0 : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || report) begin
      slot0_valid <= 1'b0;
      slot0_seq   <= '0;
      slot0_flags <= '0;
    end else if (step && last_byte) begin
      slot0_valid <= verdict.ok;
      slot0_seq   <= verdict.seq;
      slot0_flags <= verdict.flags;
    end
  end

endmodule

@@ dv/tb_dual_copy_record_resolver.sv @@
// Self-checking testbench for dual_copy_record_resolver: record copy streams, verdict check.
`timescale 1ns / 100ps

module tb_dual_copy_record_resolver;
  import dcrr_pkg::*;

  localparam int unsigned HDR_LEN     = DEF_HDR_BYTES;
  localparam int unsigned REC_LEN     = DEF_HDR_BYTES + DEF_BODY_BYTES;
  localparam int unsigned NUM_PHASES  = 5;
  localparam int unsigned PHASE_ITEMS = 16;
  localparam int unsigned SETTLE_CYC  = 8;
  localparam int unsigned IDLE_LIMIT  = 1000;

  typedef enum int {
    CK_GOOD, CK_MAGIC, CK_SCHEMA, CK_LENGTH, CK_CRC, CK_FAULT, CK_SHORT, CK_LONG, CK_TINY
  } copy_kind_t;

  typedef struct {
    logic [7:0]  data;
    logic        copy;
    logic        fault;
    logic        last;
    int unsigned gap;
    bit          drain_first;
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        copy_index = 1'b0;
  logic        read_fault = 1'b0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        config_found;
  logic        chosen_copy;
  logic [31:0] chosen_seq;
  logic [31:0] chosen_flags;
  logic        first_valid;
  logic        second_valid;
  logic [31:0] next_seq;
  logic        write_target;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = REG_EXPECTED_MAGIC;
  logic [31:0] cfg_data = 32'h0;

  dual_copy_record_resolver u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .copy_index   (copy_index),
    .read_fault   (read_fault),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .config_found (config_found),
    .chosen_copy  (chosen_copy),
    .chosen_seq   (chosen_seq),
    .chosen_flags (chosen_flags),
    .first_valid  (first_valid),
    .second_valid (second_valid),
    .next_seq     (next_seq),
    .write_target (write_target),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  byte_item_t  byte_stream[$];
  result_t     pending_verdicts[$];
  int unsigned mismatches = 0;

  // predictor state: copy in flight, held copy-0 verdict, register copies
  logic [31:0] cur_crc = CRC_SEED;
  int unsigned cur_count = 0;
  logic [31:0] cur_magic = '0;
  logic [31:0] cur_schema = '0;
  logic [31:0] cur_length = '0;
  logic [31:0] cur_seq = '0;
  logic [31:0] cur_stored_crc = '0;
  logic [31:0] cur_flags = '0;
  logic        cur_fault = 1'b0;
  logic        held_ok = 1'b0;
  logic [31:0] held_seq = '0;
  logic [31:0] held_flags = '0;
  logic [31:0] exp_magic = '0;
  logic [15:0] exp_max_schema = 16'(MAX_SCHEMA_RESET);

  // stimulus generation state
  logic [31:0] gen_magic = '0;
  logic [15:0] gen_max_schema = 16'(MAX_SCHEMA_RESET);
  logic [31:0] gen_last_seq = '0;
  int unsigned gen_items = 0;
  bit          drain_req = 1'b0;

  bit          byte_taken = 1'b0;
  bit          result_taken = 1'b0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  bit          rx_calm = 1'b0;
  int unsigned idle_cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // reflected CRC-32, data bit folded in as each bit shifts out
  function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] d);
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ d[k]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic logic [31:0] put_byte(input logic [31:0] w, input int unsigned pos,
                                           input int unsigned off, input int unsigned size,
                                           input logic [7:0] b);
    if (pos >= off && pos < off + size) w[8*(pos-off) +: 8] = b;
    return w;
  endfunction

  function automatic bit copy_passes();
    return !cur_fault && cur_count == REC_LEN && cur_magic == exp_magic &&
           cur_schema[15:0] <= exp_max_schema && cur_length[15:0] == 16'(REC_LEN) &&
           cur_stored_crc == ~cur_crc;
  endfunction

  task automatic clear_copy_state();
    cur_crc = CRC_SEED;
    cur_count = 0;
    cur_magic = '0;
    cur_schema = '0;
    cur_length = '0;
    cur_seq = '0;
    cur_stored_crc = '0;
    cur_flags = '0;
    cur_fault = 1'b0;
  endtask

  task automatic track_record_byte(input logic [7:0] b, input logic sel, input logic flt,
                                   input logic fin);
    result_t     r;
    logic        ok1;
    logic [31:0] s0;
    logic [31:0] s1;
    if (flt) cur_fault = 1'b1;
    if (cur_count < REC_LEN) begin
      cur_magic      = put_byte(cur_magic, cur_count, MAGIC_OFFSET, 4, b);
      cur_schema     = put_byte(cur_schema, cur_count, SCHEMA_OFFSET, 2, b);
      cur_length     = put_byte(cur_length, cur_count, LENGTH_OFFSET, 2, b);
      cur_seq        = put_byte(cur_seq, cur_count, DEF_SEQ_OFFSET, 4, b);
      cur_stored_crc = put_byte(cur_stored_crc, cur_count, DEF_CRC_OFFSET, 4, b);
      cur_flags      = put_byte(cur_flags, cur_count, DEF_FLAGS_OFFSET, 4, b);
      if (cur_count >= HDR_LEN) cur_crc = crc32_update(cur_crc, b);
      cur_count++;
    end
    if (!fin) return;
    if (!sel) begin
      held_ok = copy_passes();
      held_seq = cur_seq;
      held_flags = cur_flags;
    end else begin
      ok1 = copy_passes();
      s0 = held_ok ? held_seq : 32'h0;
      s1 = ok1 ? cur_seq : 32'h0;
      r = '0;
      r.config_found = held_ok || ok1;
      if (held_ok && (!ok1 || s0 >= s1)) begin
        r.chosen_copy = 1'b0;
        r.chosen_seq = s0;
        r.chosen_flags = held_flags;
      end else if (ok1) begin
        r.chosen_copy = 1'b1;
        r.chosen_seq = s1;
        r.chosen_flags = cur_flags;
      end
      r.first_valid = held_ok;
      r.second_valid = ok1;
      r.next_seq = ((s0 >= s1) ? s0 : s1) + 32'd1;
      if (!held_ok) r.write_target = 1'b0;
      else if (!ok1) r.write_target = 1'b1;
      else r.write_target = (s0 <= s1) ? 1'b0 : 1'b1;
      pending_verdicts.push_back(r);
      held_ok = 1'b0;
      held_seq = '0;
      held_flags = '0;
    end
    clear_copy_state();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      mismatches++;
    end
  endtask

  function automatic int unsigned draw_gap(input int unsigned mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 19);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
  endfunction

  task automatic push_byte(input logic [7:0] d, input logic c, input logic f, input logic l,
                           input int unsigned gap);
    byte_item_t it;
    it.data = d;
    it.copy = c;
    it.fault = f;
    it.last = l;
    it.gap = gap;
    it.drain_first = drain_req;
    drain_req = 1'b0;
    byte_stream.push_back(it);
    gen_items++;
  endtask

  function automatic logic [31:0] pick_seq();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'hFFFF_FFFE;
      3: return gen_last_seq;
      4: return gen_last_seq + 32'd1;
      5: return gen_last_seq - 32'd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic copy_kind_t pick_kind();
    case ($urandom_range(0, 15))
      9:  return CK_MAGIC;
      10: return CK_SCHEMA;
      11: return CK_LENGTH;
      12: return CK_CRC;
      13: return CK_FAULT;
      14: return CK_SHORT;
      15: return CK_LONG;
      default: return CK_GOOD;
    endcase
  endfunction

  task automatic push_copy(input logic sel, input copy_kind_t kind);
    logic [7:0]  rec [REC_LEN];
    logic [31:0] magic;
    logic [31:0] seq;
    logic [31:0] flags;
    logic [31:0] crc;
    logic [15:0] schema;
    logic [15:0] len;
    int unsigned n;
    int unsigned fault_pos;
    int unsigned gmode;
    logic [7:0]  d;
    logic        f;
    gmode = $urandom_range(0, 2);
    foreach (rec[i]) rec[i] = 8'($urandom);
    magic = gen_magic;
    seq = pick_seq();
    if (!sel) gen_last_seq = seq;
    flags = $urandom;
    len = 16'(REC_LEN);
    case ($urandom_range(0, 3))
      0: schema = 16'h0;
      1: schema = gen_max_schema;
      default: schema = 16'($urandom_range(0, gen_max_schema));
    endcase
    n = REC_LEN;
    case (kind)
      CK_MAGIC:  magic = gen_magic ^ (32'h1 << $urandom_range(0, 31));
      CK_SCHEMA: if (gen_max_schema != 16'hFFFF)
                   schema = 16'($urandom_range(gen_max_schema + 1, 16'hFFFF));
      CK_LENGTH: len = len ^ 16'($urandom_range(1, 16'hFFFF));
      CK_SHORT:  n = $urandom_range(1, REC_LEN - 1);
      CK_LONG:   n = REC_LEN + $urandom_range(1, 24);
      CK_TINY:   n = $urandom_range(1, 6);
      default: ;
    endcase
    crc = CRC_SEED;
    for (int i = HDR_LEN; i < REC_LEN; i++) crc = crc32_update(crc, rec[i]);
    crc = ~crc;
    if (kind == CK_CRC) crc = crc ^ (32'h1 << $urandom_range(0, 31));
    for (int k = 0; k < 4; k++) begin
      rec[MAGIC_OFFSET + k] = magic[8*k +: 8];
      rec[DEF_SEQ_OFFSET + k] = seq[8*k +: 8];
      rec[DEF_CRC_OFFSET + k] = crc[8*k +: 8];
      rec[DEF_FLAGS_OFFSET + k] = flags[8*k +: 8];
    end
    for (int k = 0; k < 2; k++) begin
      rec[SCHEMA_OFFSET + k] = schema[8*k +: 8];
      rec[LENGTH_OFFSET + k] = len[8*k +: 8];
    end
    fault_pos = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      d = (i < REC_LEN) ? rec[i] : 8'($urandom);
      if (kind == CK_TINY) f = ($urandom_range(0, 3) == 0);
      else f = (kind == CK_FAULT) && (i == fault_pos);
      // copy_index only matters on the last byte
      push_byte(d, (i == n - 1) ? sel : 1'($urandom), f, i == n - 1, draw_gap(gmode));
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (byte_stream.size() != 0 || in_valid || pending_verdicts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    logic       nv;
    byte_item_t nxt;
    nv = in_valid;
    if (byte_taken) nv = 1'b0;
    if (!rst && !nv && byte_stream.size() != 0) begin
      if (tx_wait < byte_stream[0].gap) begin
        tx_wait++;
      end else if (!(byte_stream[0].drain_first && pending_verdicts.size() != 0)) begin
        nxt = byte_stream.pop_front();
        data_byte <= nxt.data;
        copy_index <= nxt.copy;
        read_fault <= nxt.fault;
        last_byte <= nxt.last;
        nv = 1'b1;
        tx_wait = 0;
      end
    end
    in_valid <= nv;
  end

  // receiver backpressure
  always @(negedge clk) begin
    logic nr;
    nr = out_ready;
    if (result_taken) begin
      nr = 1'b0;
      if ($urandom_range(0, 9) == 0) rx_calm = !rx_calm;
      rx_wait = rx_calm ? 0 : $urandom_range(0, 19);
    end
    if (!rst && !nr) begin
      if (rx_wait == 0) nr = 1'b1;
      else rx_wait--;
    end
    out_ready <= nr;
  end

  // transfers: register writes, byte prediction, result check
  always @(posedge clk) begin
    result_t want;
    byte_taken = 1'b0;
    result_taken = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_EXPECTED_MAGIC: exp_magic = cfg_data;
          REG_MAX_SCHEMA:     exp_max_schema = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        result_taken = 1'b1;
        if (pending_verdicts.size() == 0) begin
          $error("result transfer with no verdict pending");
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          check_field("config_found", 32'(want.config_found), 32'(config_found));
          check_field("chosen_copy", 32'(want.chosen_copy), 32'(chosen_copy));
          check_field("chosen_seq", want.chosen_seq, chosen_seq);
          check_field("chosen_flags", want.chosen_flags, chosen_flags);
          check_field("first_valid", 32'(want.first_valid), 32'(first_valid));
          check_field("second_valid", 32'(want.second_valid), 32'(second_valid));
          check_field("next_seq", want.next_seq, next_seq);
          check_field("write_target", 32'(want.write_target), 32'(write_target));
        end
      end
      if (in_valid && in_ready) begin
        byte_taken = 1'b1;
        track_record_byte(data_byte, copy_index, read_fault, last_byte);
      end
    end
  end

  // watchdog: no transfer on any channel for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        settle();
        case (ph)
          1: begin
            gen_magic = 32'hFFFF_FFFF;
            gen_max_schema = 16'h0000;
          end
          2: begin
            gen_magic = $urandom;
            gen_max_schema = 16'hFFFF;
          end
          4: begin
            gen_magic = 32'h0;
            gen_max_schema = 16'(MAX_SCHEMA_RESET);
          end
          default: begin
            gen_magic = $urandom;
            gen_max_schema = 16'($urandom);
          end
        endcase
        write_reg(REG_EXPECTED_MAGIC, gen_magic);
        write_reg(REG_MAX_SCHEMA, {16'($urandom), gen_max_schema});
      end

      if (ph == 0) begin
        // copy 1 alone, nothing valid
        push_byte(8'h00, 1'b1, 1'b0, 1'b1, 0);
        // faulted copy 0 tagged as copy 1 until its last byte
        push_byte(8'hFF, 1'b1, 1'b1, 1'b0, 3);
        push_byte(8'h00, 1'b0, 1'b0, 1'b1, 0);
        // second copy 0 in a row replaces the held verdict
        push_byte(8'hA5, 1'b0, 1'b0, 1'b1, 1);
        push_byte(8'h5A, 1'b0, 1'b1, 1'b0, 0);
        push_byte(8'h80, 1'b1, 1'b0, 1'b0, 0);
        push_byte(8'h01, 1'b1, 1'b0, 1'b1, 19);
        // faulted single-byte copy 1
        push_byte(8'hFF, 1'b1, 1'b1, 1'b1, 0);
        // hold the sender until every result has come, then a clean pair
        drain_req = 1'b1;
        push_copy(1'b0, CK_GOOD);
        push_copy(1'b1, CK_GOOD);
      end

      // short copies of either index until PHASE_ITEMS bytes are queued, then one pair of random kinds
      gen_items = 0;
      while (gen_items < PHASE_ITEMS) push_copy(1'($urandom), CK_TINY);
      // now and then hold the sender until every result has come before the pair
      drain_req = ($urandom_range(0, 15) == 0);
      push_copy(1'b0, pick_kind());
      push_copy(1'b1, pick_kind());
    end

    settle();
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
design/dcrr_pkg.sv
design/dcrr_copy_track.sv
design/dcrr_select.sv
design/dual_copy_record_resolver.sv
dv/tb_dual_copy_record_resolver.sv
